// ===== rtl/gemm3l_pkg.sv =====
// Shared types and constants for the three-layout GEMM engine.
`default_nettype none
package gemm3l_pkg;

    localparam int STORE_DEPTH_DEF = 1024;
    localparam int MAX_DIM_DEF     = 64;

    localparam logic [2:0] KIND_LOAD_A  = 3'd0;
    localparam logic [2:0] KIND_LOAD_B  = 3'd1;
    localparam logic [2:0] KIND_LOAD_C  = 3'd2;
    localparam logic [2:0] KIND_COMPUTE = 3'd3;
    localparam logic [2:0] KIND_READ_C  = 3'd4;

    localparam logic [2:0] CFG_LAYOUT = 3'd0;
    localparam logic [2:0] CFG_DIM_M  = 3'd1;
    localparam logic [2:0] CFG_DIM_N  = 3'd2;
    localparam logic [2:0] CFG_DIM_K  = 3'd3;
    localparam logic [2:0] CFG_BETA   = 3'd4;

    localparam logic [1:0] LAYOUT_FWD   = 2'd0;
    localparam logic [1:0] LAYOUT_WGRAD = 2'd1;
    localparam logic [1:0] LAYOUT_IGRAD = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_INIT,
        S_MAC,
        S_DRAIN1,
        S_DRAIN2,
        S_WRITE,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INIT,
        OP_MAC
    } t_op;

    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic wr_c_load;
        logic wr_c_acc;
        logic rd_c_ci;
        t_op  op;
        logic cap_idx;
        logic out_load;
        logic out_is_read;
        logic out_status;
    } t_cmd;

endpackage
`default_nettype wire

// ===== rtl/gemm_engine_three_layouts_core.sv =====
// Top level of the three-layout Q16.16 GEMM engine.
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one transaction per item:
//   load A, load B, load prior C, compute, or read C. Loads give no result.
//   A read goes through the S_READ state, then gives one registered result.
//   A compute walks every C element: it fetches and scales prior C (S_INIT),
//   does one multiply-accumulate per inner-dimension term (S_MAC), drains the
//   pipeline (S_DRAIN1, S_DRAIN2) and writes the element (S_WRITE), one at a
//   time; the single multiplier and the one-read-port stores set this.
//   Its result (value 0, status) comes when it ends.
//   Output channel (o_out_valid / i_out_stall) is a single result register;
//   while it holds a stalled result the input stalls for every item, and a
//   compute that ends meanwhile waits for the register to free. Configuration
//   writes (i_cfg_valid / o_cfg_ready) are taken every cycle and belong only
//   to idle periods.
//   Reset (i_rst_n low, synchronous) sets layout 0, dims 1, beta 0 and empties
//   the result register; store contents are undefined until loaded.
`default_nettype none
module gemm_engine_three_layouts_core import gemm3l_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int MAX_DIM     = MAX_DIM_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [2:0]         i_kind,
    input  wire logic [9:0]         i_elem_index,
    input  wire logic signed [31:0] i_elem_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_out_value,
    output logic [9:0]              o_out_index,
    output logic                    o_out_status,
    output logic                    o_out_is_read
);

    localparam int PW = $clog2(STORE_DEPTH) + 1;

    t_cmd w_cmd;
    logic [PW-1:0] w_a_ptr, w_b_ptr, w_c_ptr;
    logic signed [31:0] w_beta;

    gemm3l_ctrl #(
        .STORE_DEPTH(STORE_DEPTH),
        .MAX_DIM    (MAX_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_elem_index(i_elem_index),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .o_a_ptr     (w_a_ptr),
        .o_b_ptr     (w_b_ptr),
        .o_c_ptr     (w_c_ptr),
        .o_beta      (w_beta)
    );

    gemm3l_datapath #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_a_ptr      (w_a_ptr),
        .i_b_ptr      (w_b_ptr),
        .i_c_ptr      (w_c_ptr),
        .i_beta       (w_beta),
        .i_elem_index (i_elem_index),
        .i_elem_value (i_elem_value),
        .o_out_value  (o_out_value),
        .o_out_index  (o_out_index),
        .o_out_status (o_out_status),
        .o_out_is_read(o_out_is_read)
    );

endmodule
`default_nettype wire

// ===== rtl/gemm3l_datapath.sv =====
// Datapath: A/B/C stores, multiply-accumulate pipeline and result register.
`default_nettype none
module gemm3l_datapath import gemm3l_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    localparam int PW = $clog2(STORE_DEPTH) + 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire logic [PW-1:0]      i_a_ptr,
    input  wire logic [PW-1:0]      i_b_ptr,
    input  wire logic [PW-1:0]      i_c_ptr,
    input  wire logic signed [31:0] i_beta,
    input  wire logic [9:0]         i_elem_index,
    input  wire logic signed [31:0] i_elem_value,
    output logic signed [31:0]      o_out_value,
    output logic [9:0]              o_out_index,
    output logic                    o_out_status,
    output logic                    o_out_is_read
);

    localparam int AW = $clog2(STORE_DEPTH);

    logic [31:0] r_a_mem [STORE_DEPTH];
    logic [31:0] r_b_mem [STORE_DEPTH];
    logic [31:0] r_c_mem [STORE_DEPTH];
    logic signed [31:0] r_a_rd, r_b_rd, r_c_rd;

    logic [AW-1:0] w_ld_addr, w_c_rd_addr;
    logic signed [31:0] w_mul_a, w_mul_b;
    logic signed [63:0] w_prod;
    logic signed [64:0] w_sum;
    logic signed [63:0] w_sum_sat, w_shift;
    logic signed [31:0] w_sat32;

    t_op r_p1_op, r_p2_op;
    logic signed [63:0] r_p2_prod, r_acc;
    logic [9:0] r_rd_index;

    assign w_ld_addr   = AW'(i_elem_index);
    assign w_c_rd_addr = i_cmd.rd_c_ci ? i_c_ptr[AW-1:0] : w_ld_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            r_a_mem[w_ld_addr] <= i_elem_value;
        end
        r_a_rd <= r_a_mem[i_a_ptr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_b) begin
            r_b_mem[w_ld_addr] <= i_elem_value;
        end
        r_b_rd <= r_b_mem[i_b_ptr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_c_load) begin
            r_c_mem[w_ld_addr] <= i_elem_value;
        end else if (i_cmd.wr_c_acc) begin
            r_c_mem[i_c_ptr[AW-1:0]] <= w_sat32;
        end
        r_c_rd <= r_c_mem[w_c_rd_addr];
    end

    always_comb begin
        if (r_p1_op == OP_INIT) begin
            w_mul_a = r_c_rd;
            w_mul_b = i_beta;
        end else begin
            w_mul_a = r_a_rd;
            w_mul_b = r_b_rd;
        end
        w_prod = w_mul_a * w_mul_b;
    end

    // 64-bit saturating accumulate
    always_comb begin
        w_sum = {r_acc[63], r_acc} + {r_p2_prod[63], r_p2_prod};
        if (w_sum[64] != w_sum[63]) begin
            w_sum_sat = w_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            w_sum_sat = w_sum[63:0];
        end
    end

    // floor shift by 16, saturate to 32 bits
    always_comb begin
        w_shift = r_acc >>> 16;
        if ((&w_shift[63:31]) || !(|w_shift[63:31])) begin
            w_sat32 = w_shift[31:0];
        end else begin
            w_sat32 = w_shift[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_op <= OP_NONE;
            r_p2_op <= OP_NONE;
            r_acc   <= '0;
        end else begin
            r_p1_op <= i_cmd.op;
            r_p2_op <= r_p1_op;
            if (r_p2_op == OP_INIT) begin
                r_acc <= r_p2_prod;
            end else if (r_p2_op == OP_MAC) begin
                r_acc <= w_sum_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p1_op == OP_INIT && i_beta == 32'sd0) begin
            r_p2_prod <= '0;
        end else begin
            r_p2_prod <= w_prod;
        end
        if (i_cmd.cap_idx) begin
            r_rd_index <= i_elem_index;
        end
        if (i_cmd.out_load) begin
            o_out_value   <= (i_cmd.out_is_read && !i_cmd.out_status) ? r_c_rd : 32'sd0;
            o_out_index   <= i_cmd.out_is_read ? r_rd_index : 10'd0;
            o_out_status  <= i_cmd.out_status;
            o_out_is_read <= i_cmd.out_is_read;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/gemm3l_ctrl.sv =====
// Controller: configuration registers, item decode and compute sequencer.
`default_nettype none
module gemm3l_ctrl import gemm3l_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int MAX_DIM     = MAX_DIM_DEF,
    localparam int PW = $clog2(STORE_DEPTH) + 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [2:0]         i_kind,
    input  wire logic [9:0]         i_elem_index,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_cmd                    o_cmd,
    output logic [PW-1:0]           o_a_ptr,
    output logic [PW-1:0]           o_b_ptr,
    output logic [PW-1:0]           o_c_ptr,
    output logic signed [31:0]      o_beta
);

    t_state r_state, n_state;
    logic [1:0] r_layout;
    logic [6:0] r_dim_m, r_dim_n, r_dim_k;
    logic signed [31:0] r_beta;
    logic r_out_valid, n_out_valid;
    logic r_status, n_status;
    logic [6:0] r_row, n_row, r_col, n_col, r_dep, n_dep;
    logic [PW-1:0] r_a_base, n_a_base, r_b_base, n_b_base;
    logic [PW-1:0] r_a_ptr, n_a_ptr, r_b_ptr, n_b_ptr, r_c_ptr, n_c_ptr;

    logic [6:0] w_rows, w_cols, w_depth;
    logic [PW-1:0] w_row_step_a, w_stride_a, w_col_step_b, w_stride_b;
    logic [13:0] w_mk, w_mn, w_nk, w_ext_a, w_ext_b, w_ext_c;
    logic w_err, w_accept, w_inside, w_out_free;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_a_ptr     = r_a_ptr;
    assign o_b_ptr     = r_b_ptr;
    assign o_c_ptr     = r_c_ptr;
    assign o_beta      = r_beta;

    assign w_mk = 14'(r_dim_m * r_dim_k);
    assign w_mn = 14'(r_dim_m * r_dim_n);
    assign w_nk = 14'(r_dim_n * r_dim_k);

    always_comb begin
        unique case (r_layout)
            LAYOUT_WGRAD: begin
                w_rows = r_dim_n; w_cols = r_dim_k; w_depth = r_dim_m;
                w_ext_a = w_mn; w_ext_b = w_mk; w_ext_c = w_nk;
                w_row_step_a = PW'(1);       w_stride_a = PW'(r_dim_n);
                w_col_step_b = PW'(1);       w_stride_b = PW'(r_dim_k);
            end
            LAYOUT_IGRAD: begin
                w_rows = r_dim_m; w_cols = r_dim_k; w_depth = r_dim_n;
                w_ext_a = w_mn; w_ext_b = w_nk; w_ext_c = w_mk;
                w_row_step_a = PW'(r_dim_n); w_stride_a = PW'(1);
                w_col_step_b = PW'(1);       w_stride_b = PW'(r_dim_k);
            end
            default: begin
                w_rows = r_dim_m; w_cols = r_dim_n; w_depth = r_dim_k;
                w_ext_a = w_mk; w_ext_b = w_nk; w_ext_c = w_mn;
                w_row_step_a = PW'(r_dim_k); w_stride_a = PW'(1);
                w_col_step_b = PW'(r_dim_k); w_stride_b = PW'(1);
            end
        endcase
    end

    assign w_err = (r_layout != LAYOUT_FWD && r_layout != LAYOUT_WGRAD
                    && r_layout != LAYOUT_IGRAD)
                || (32'(r_dim_m) > MAX_DIM) || (32'(r_dim_n) > MAX_DIM)
                || (32'(r_dim_k) > MAX_DIM)
                || (32'(w_ext_a) > STORE_DEPTH) || (32'(w_ext_b) > STORE_DEPTH)
                || (32'(w_ext_c) > STORE_DEPTH);

    assign w_inside   = 32'(i_elem_index) < STORE_DEPTH;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout <= LAYOUT_FWD;
            r_dim_m  <= 7'd1;
            r_dim_n  <= 7'd1;
            r_dim_k  <= 7'd1;
            r_beta   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LAYOUT: r_layout <= i_cfg_data[1:0];
                CFG_DIM_M:  r_dim_m  <= i_cfg_data[6:0];
                CFG_DIM_N:  r_dim_n  <= i_cfg_data[6:0];
                CFG_DIM_K:  r_dim_k  <= i_cfg_data[6:0];
                CFG_BETA:   r_beta   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_status    <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_dep       <= '0;
            r_a_base    <= '0;
            r_b_base    <= '0;
            r_a_ptr     <= '0;
            r_b_ptr     <= '0;
            r_c_ptr     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_status    <= n_status;
            r_row       <= n_row;
            r_col       <= n_col;
            r_dep       <= n_dep;
            r_a_base    <= n_a_base;
            r_b_base    <= n_b_base;
            r_a_ptr     <= n_a_ptr;
            r_b_ptr     <= n_b_ptr;
            r_c_ptr     <= n_c_ptr;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = (r_out_valid && i_out_stall) ? 1'b1 : 1'b0;
        n_status    = r_status;
        n_row       = r_row;
        n_col       = r_col;
        n_dep       = r_dep;
        n_a_base    = r_a_base;
        n_b_base    = r_b_base;
        n_a_ptr     = r_a_ptr;
        n_b_ptr     = r_b_ptr;
        n_c_ptr     = r_c_ptr;
        o_cmd       = '{op: OP_NONE, default: 1'b0};

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_kind)
                        KIND_LOAD_A: o_cmd.wr_a      = w_inside;
                        KIND_LOAD_B: o_cmd.wr_b      = w_inside;
                        KIND_LOAD_C: o_cmd.wr_c_load = w_inside;
                        KIND_READ_C: begin
                            o_cmd.cap_idx = 1'b1;
                            n_status      = !w_inside;
                            n_state       = S_READ;
                        end
                        KIND_COMPUTE: begin
                            n_row    = '0;
                            n_col    = '0;
                            n_a_base = '0;
                            n_b_base = '0;
                            n_c_ptr  = '0;
                            if (w_err) begin
                                n_status = 1'b1;
                                n_state  = S_DONE;
                            end else if (w_rows == 7'd0 || w_cols == 7'd0) begin
                                n_status = 1'b0;
                                n_state  = S_DONE;
                            end else begin
                                n_status = 1'b0;
                                n_state  = S_INIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                o_cmd.out_load    = 1'b1;
                o_cmd.out_is_read = 1'b1;
                o_cmd.out_status  = r_status;
                n_out_valid       = 1'b1;
                n_state           = S_IDLE;
            end
            S_INIT: begin
                o_cmd.op      = OP_INIT;
                o_cmd.rd_c_ci = 1'b1;
                n_a_ptr       = r_a_base;
                n_b_ptr       = r_b_base;
                n_dep         = '0;
                n_state       = (w_depth == 7'd0) ? S_DRAIN1 : S_MAC;
            end
            S_MAC: begin
                o_cmd.op = OP_MAC;
                n_a_ptr  = r_a_ptr + w_stride_a;
                n_b_ptr  = r_b_ptr + w_stride_b;
                n_dep    = r_dep + 7'd1;
                if (r_dep == w_depth - 7'd1) begin
                    n_state = S_DRAIN1;
                end
            end
            S_DRAIN1: n_state = S_DRAIN2;
            S_DRAIN2: n_state = S_WRITE;
            S_WRITE: begin
                o_cmd.wr_c_acc = 1'b1;
                n_c_ptr        = r_c_ptr + PW'(1);
                n_state        = S_INIT;
                if (r_col == w_cols - 7'd1) begin
                    n_col    = '0;
                    n_b_base = '0;
                    n_row    = r_row + 7'd1;
                    n_a_base = r_a_base + w_row_step_a;
                    if (r_row == w_rows - 7'd1) begin
                        n_row   = '0;
                        n_state = S_DONE;
                    end
                end else begin
                    n_col    = r_col + 7'd1;
                    n_b_base = r_b_base + w_col_step_b;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = r_status;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire
